FILE: src/qrs_pkg.sv
package qrs_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_REFRACTORY = 2'd0;
  localparam logic [1:0] REG_FLOOR      = 2'd1;
  localparam logic [1:0] REG_PERIOD     = 2'd2;

  localparam logic [9:0]  REFRACTORY_RESET = 10'd350;
  localparam logic [39:0] FLOOR_RESET      = 40'd512000;
  localparam logic [7:0]  PERIOD_RESET     = 8'd4;
  localparam logic [39:0] THRESHOLD_RESET  = 40'd512000;

  // Filter term order within one biquad section.
  localparam logic [2:0] TERM_B0 = 3'd0;
  localparam logic [2:0] TERM_B1 = 3'd1;
  localparam logic [2:0] TERM_A1 = 3'd2;
  localparam logic [2:0] TERM_B2 = 3'd3;
  localparam logic [2:0] TERM_A2 = 3'd4;

  localparam logic [1:0] LAST_SECTION = 2'd2;

  localparam int DIV_STEPS = 52;
  // Reciprocals scaled by 2^52, rounded up. The decay computes
  // thr - ceil(thr / 2000), which equals floor(thr * 1999 / 2000).
  localparam logic [47:0] DECAY_BIAS  = 48'd1999;
  localparam logic [51:0] DECAY_RECIP = 52'd2251799813686;
  localparam logic [51:0] RATE_RECIP  = 52'd450359962737050;
  localparam logic [23:0] BPM_SCALE = 24'd15360000;
  localparam logic [31:0] MIN_INTERVAL = 32'd250;
  localparam logic [31:0] MAX_INTERVAL = 32'd2000;

  // Q2.30 bandpass coefficients, by section and term.
  function automatic logic signed [31:0] coef_of(input logic [1:0] sec, input logic [2:0] term);
    logic signed [31:0] c;
    c = 32'sd0;
    case (sec)
      2'd0: begin
        case (term)
          TERM_B0: c = 32'sd1682565;
          TERM_B1: c = 32'sd3365129;
          TERM_A1: c = -32'sd1861399033;
          TERM_B2: c = 32'sd1682565;
          TERM_A2: c = 32'sd832879533;
          default: c = 32'sd0;
        endcase
      end
      2'd1: begin
        case (term)
          TERM_B0: c = 32'sd1073741824;
          TERM_B1: c = 32'sd0;
          TERM_A1: c = -32'sd1844259945;
          TERM_B2: c = -32'sd1073741824;
          TERM_A2: c = 32'sd895367845;
          default: c = 32'sd0;
        endcase
      end
      2'd2: begin
        case (term)
          TERM_B0: c = 32'sd1073741824;
          TERM_B1: c = 32'sh80000000;
          TERM_A1: c = -32'sd2058390328;
          TERM_B2: c = 32'sd1073741824;
          TERM_A2: c = 32'sd1002840200;
          default: c = 32'sd0;
        endcase
      end
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [47:0] r;
    if (v > 52'sh007FFFFFFFFFFF) r = 48'sh7FFFFFFFFFFF;
    else if (v < -52'sh00800000000000) r = 48'sh800000000000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

FILE: src/qrs_ram.sv
module qrs_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 37,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: src/qrs_beat_detector_unit.sv
// QRS beat detector. One 12-bit ECG sample is taken per request on the input
// channel (in_valid/in_ready) and one result per sample leaves on the output
// channel (out_valid/out_ready): window level, threshold, heart rate, beat.
// The block works on one sample at a time; in_ready is high only while it is
// idle. All products use one shared 33x33 multiplier and the interval division
// uses one radix-2 restoring divider (52 steps), both under a small sequencer.
// Divisions by constants are reciprocal multiplications on the shared multiplier.
// The bandpass runs three biquad sections of five terms each, and each term
// is formed from two partial products. A new sample can be taken in the cycle
// after the result has been registered. The result sits in an output
// register; if the receiver stalls, the next sample is still accepted and
// processed, and the block waits only when it has a second result ready
// while the first is still held.
// Synchronous reset clears the filter, window, clock and rate, sets the
// threshold to its reset value and restores the register defaults; window
// entries are marked empty by valid bits, so no clearing pass is needed.
module qrs_beat_detector_unit
  import qrs_pkg::*;
#(
  parameter int WINDOW_LENGTH = 37
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] raw_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [39:0] integrated_level,
  output logic [39:0] threshold_level,
  output logic [15:0] heart_rate,
  output logic        beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int PW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam logic [51:0] WIN_RECIP =
    52'(((64'd1 << 52) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FILT    = 4'd1;
  localparam logic [3:0] S_SQ0     = 4'd2;
  localparam logic [3:0] S_SQ1     = 4'd3;
  localparam logic [3:0] S_SQ2     = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_TEST    = 4'd6;
  localparam logic [3:0] S_RMUL    = 4'd7;
  localparam logic [3:0] S_DECDONE = 4'd8;
  localparam logic [3:0] S_INST    = 4'd9;
  localparam logic [3:0] S_RAVG    = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  logic [3:0] state;
  logic [3:0] div_ret;

  logic [9:0]  refractory_ms;
  logic [39:0] threshold_floor;
  logic [7:0]  sample_period_ms;

  logic signed [47:0] delays [6];
  logic signed [47:0] x_val;
  logic signed [47:0] y_val;
  logic signed [47:0] previous_filtered;
  logic signed [51:0] sum;
  logic signed [81:0] acc;
  logic signed [65:0] prod;
  logic [1:0] sec;
  logic [2:0] term;
  logic [1:0] phase;

  logic [48:0] mag;
  logic [39:0] old_val;
  logic [47:0] window_sum;
  logic [PW-1:0] window_pos;
  logic [WINDOW_LENGTH-1:0] win_valid;
  logic [39:0] ram_rdata;
  logic [39:0] sq;
  logic        ram_we;

  logic [39:0] beat_threshold;
  logic [39:0] level;
  logic [31:0] elapsed_ms;
  logic [31:0] last_beat_ms;
  logic [15:0] rate_average;
  logic        beat_seen;
  logic        beat_q;

  logic [51:0] div_quo;
  logic [10:0] div_rem;
  logic [10:0] div_den;
  logic [5:0]  div_cnt;

  // Reciprocal multiplication: quotient = (rn * rm) >> 52.
  logic [47:0] rn;
  logic [51:0] rm;
  logic [99:0] racc;
  logic [2:0]  rcnt;
  logic [3:0]  rret;
  logic [39:0] rq;
  logic [39:0] dec_thr;

  // Shared multiplier operands.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [31:0] coef_val;
  logic signed [47:0] v_op;
  logic               term_uses_y;
  logic               term_sub;
  logic signed [51:0] m_val;
  logic signed [51:0] sum_new;
  logic signed [47:0] sum_sat;
  logic signed [47:0] w_init;
  logic signed [48:0] diff;
  logic [47:0] window_sum_next;
  logic [31:0] delta;
  logic [43:0] beat_thr_sum;
  logic [11:0] div_trial;
  logic [19:0] rate_mix;
  logic        cfg_write;
  logic        out_free;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:3])
      REG_REFRACTORY: prdata = {54'd0, refractory_ms};
      REG_FLOOR:      prdata = {24'd0, threshold_floor};
      REG_PERIOD:     prdata = {56'd0, sample_period_ms};
      default:        prdata = 64'd0;
    endcase
  end

  assign term_uses_y = (term == TERM_A1) || (term == TERM_A2);
  assign term_sub    = term_uses_y;
  assign v_op        = term_uses_y ? y_val : x_val;
  assign m_val       = acc[81:30];
  assign sum_new     = term_sub ? (sum - m_val) : (sum + m_val);
  assign sum_sat     = sat48(sum_new);
  assign w_init      = delays[{sec, (term == TERM_B1)}];
  assign coef_val    = coef_of(sec, term);
  assign rq          = racc[91:52];
  assign dec_thr     = beat_threshold - rq;

  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    case (state)
      S_FILT: begin
        mul_a = {coef_val[31], coef_val};
        if (phase == 2'd0) mul_b = {{9{v_op[47]}}, v_op[47:24]};
        else mul_b = {9'd0, v_op[23:0]};
      end
      S_SQ1: begin
        mul_a = {1'b0, mag[31:0]};
        mul_b = {1'b0, mag[31:0]};
      end
      S_RMUL: begin
        case (rcnt)
          3'd0: begin
            mul_a = {9'd0, rn[23:0]};
            mul_b = {9'd0, rm[23:0]};
          end
          3'd1: begin
            mul_a = {9'd0, rn[23:0]};
            mul_b = {5'd0, rm[51:24]};
          end
          3'd2: begin
            mul_a = {9'd0, rn[47:24]};
            mul_b = {9'd0, rm[23:0]};
          end
          3'd3: begin
            mul_a = {9'd0, rn[47:24]};
            mul_b = {5'd0, rm[51:24]};
          end
          default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
          end
        endcase
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  assign diff = {x_val[47], x_val} - {previous_filtered[47], previous_filtered};
  assign sq = (|mag[48:32]) ? 40'hFF_FFFF_FFFF : prod[63:24];
  assign window_sum_next = window_sum - {8'd0, old_val} + {8'd0, sq};
  assign delta = elapsed_ms - last_beat_ms;
  assign beat_thr_sum = {4'd0, rq} + {1'b0, beat_threshold, 3'd0}
                        - {4'd0, beat_threshold} + 44'd4;
  assign div_trial = {div_rem, div_quo[51]};
  assign rate_mix = {rate_average, 3'd0} + {4'd0, rate_average} + {4'd0, div_quo[15:0]} + 20'd5;
  assign ram_we = (state == S_SQ2);

  qrs_ram #(.WIDTH(40), .DEPTH(WINDOW_LENGTH)) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (window_pos),
    .wdata (sq),
    .raddr (window_pos),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      refractory_ms    <= REFRACTORY_RESET;
      threshold_floor  <= FLOOR_RESET;
      sample_period_ms <= PERIOD_RESET;
      for (int i = 0; i < 6; i++) delays[i] <= '0;
      previous_filtered <= '0;
      window_sum       <= '0;
      window_pos       <= '0;
      win_valid        <= '0;
      beat_threshold   <= THRESHOLD_RESET;
      elapsed_ms       <= '0;
      last_beat_ms     <= '0;
      rate_average     <= '0;
      beat_seen        <= 1'b0;
      div_cnt          <= '0;
    end else begin
      if (cfg_write) begin
        case (paddr[4:3])
          REG_REFRACTORY: refractory_ms <= pwdata[9:0];
          REG_FLOOR:      threshold_floor <= pwdata[39:0];
          REG_PERIOD:     sample_period_ms <= pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x_val <= {20'd0, raw_sample, 16'd0};
            sec   <= '0;
            term  <= TERM_B0;
            phase <= '0;
            state <= S_FILT;
          end
        end
        S_FILT: begin
          phase <= phase + 2'd1;
          case (phase)
            2'd0: begin
              prod <= mul_a * mul_b;
              if (term == TERM_B0 || term == TERM_B1) sum <= {{4{w_init[47]}}, w_init};
              else if (term == TERM_B2) sum <= '0;
            end
            2'd1: begin
              acc  <= ({{16{prod[65]}}, prod} <<< 24) + 82'sd536870912;
              prod <= mul_a * mul_b;
            end
            2'd2: acc <= acc + {{16{prod[65]}}, prod};
            default: begin
              sum <= sum_new;
              if (term == TERM_B0) y_val <= sum_sat;
              if (term == TERM_A1) delays[{sec, 1'b0}] <= sum_sat;
              if (term == TERM_A2) begin
                delays[{sec, 1'b1}] <= sum_sat;
                x_val <= y_val;
                term  <= TERM_B0;
                sec   <= sec + 2'd1;
                if (sec == LAST_SECTION) state <= S_SQ0;
              end else begin
                term <= term + 3'd1;
              end
            end
          endcase
        end
        S_SQ0: begin
          previous_filtered <= x_val;
          mag     <= diff[48] ? 49'(-diff) : diff;
          old_val <= win_valid[window_pos] ? ram_rdata : '0;
          state   <= S_SQ1;
        end
        S_SQ1: begin
          prod  <= mul_a * mul_b;
          state <= S_SQ2;
        end
        S_SQ2: begin
          window_sum <= window_sum_next;
          win_valid[window_pos] <= 1'b1;
          window_pos <= (window_pos == PW'(WINDOW_LENGTH - 1)) ? '0 : window_pos + 1'b1;
          elapsed_ms <= elapsed_ms + {24'd0, sample_period_ms};
          rn      <= window_sum_next;
          rm      <= WIN_RECIP;
          rcnt    <= '0;
          rret    <= S_TEST;
          state   <= S_RMUL;
        end
        S_RMUL: begin
          // Four partial products, each summed in the cycle after it is formed.
          prod <= mul_a * mul_b;
          rcnt <= rcnt + 3'd1;
          case (rcnt)
            3'd0: racc <= '0;
            3'd1: racc <= {48'd0, prod[51:0]};
            3'd2, 3'd3: racc <= racc + {24'd0, prod[51:0], 24'd0};
            default: begin
              racc  <= racc + {prod[51:0], 48'd0};
              state <= rret;
            end
          endcase
        end
        S_DIV: begin
          if (div_trial >= {1'b0, div_den}) begin
            div_rem <= 11'(div_trial - {1'b0, div_den});
            div_quo <= {div_quo[50:0], 1'b1};
          end else begin
            div_rem <= div_trial[10:0];
            div_quo <= {div_quo[50:0], 1'b0};
          end
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd1) state <= div_ret;
        end
        S_TEST: begin
          level   <= rq;
          beat_q  <= 1'b0;
          if (delta < {22'd0, refractory_ms}) begin
            state <= S_FIN;
          end else if (rq > beat_threshold) begin
            beat_q         <= 1'b1;
            beat_threshold <= beat_thr_sum[42:3];
            last_beat_ms   <= elapsed_ms;
            beat_seen      <= 1'b1;
            if (beat_seen && delta > MIN_INTERVAL && delta < MAX_INTERVAL) begin
              div_quo <= {28'd0, BPM_SCALE + {14'd0, delta[10:1]}};
              div_rem <= '0;
              div_den <= delta[10:0];
              div_cnt <= 6'(DIV_STEPS);
              div_ret <= S_INST;
              state   <= S_DIV;
            end else begin
              state <= S_FIN;
            end
          end else begin
            rn    <= {8'd0, beat_threshold} + DECAY_BIAS;
            rm    <= DECAY_RECIP;
            rcnt  <= '0;
            rret  <= S_DECDONE;
            state <= S_RMUL;
          end
        end
        S_DECDONE: begin
          beat_threshold <= (dec_thr < threshold_floor) ? threshold_floor : dec_thr;
          state <= S_FIN;
        end
        S_INST: begin
          if (rate_average == '0) begin
            rate_average <= div_quo[15:0];
            state <= S_FIN;
          end else begin
            rn    <= {28'd0, rate_mix};
            rm    <= RATE_RECIP;
            rcnt  <= '0;
            rret  <= S_RAVG;
            state <= S_RMUL;
          end
        end
        S_RAVG: begin
          rate_average <= rq[15:0];
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            integrated_level <= level;
            threshold_level  <= beat_threshold;
            heart_rate       <= rate_average;
            beat             <= beat_q;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts_filter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_FILT)
    else $error("accepted sample did not start the filter");

  a_rate_after_beat: assert property (@(posedge clk) disable iff (rst)
    !beat_seen |-> rate_average == 16'd0)
    else $error("rate set before any beat");

  a_filter_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FILT |-> sec <= LAST_SECTION && term <= TERM_A2)
    else $error("filter sequencer out of range");

  a_divider_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_cnt != 6'd0)
    else $error("divider running with no steps left");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && out_valid && !out_ready |=> state == S_FIN)
    else $error("result overwrote a held output");

endmodule
